### design/bblru_pkg.sv
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared types and constants for the byte-budget LRU cache core.
// ----------------------------------------------------------------------------
package bblru_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // request kinds
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;

  // configuration register indexes
  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [31:0] object_size;
    logic [31:0] value_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       scan_start;
    logic       scan_step;
    logic       size_rd_victim;
    logic       remove_hit;
    logic       remove_victim;
    logic       touch;
    logic       insert;
    logic       pend_load;
    logic [1:0] pend_status;
    logic       pend_use_value;
    logic       out_load;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_get;
    logic too_big;
    logic scan_done;
    logic hit_now;
    logic need_evict;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage

### design/byte_budget_lru_cache_core.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_core
// LRU cache of key, size and value entries with eviction under a byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (kind, key, object_size, value_word); a transfer
//           happens when in_valid is high and in_stall is low.
//   out_* : one result (status, data_out) per request, same handshake with
//           out_stall driven by the receiver.
//   cfg_* : register writes (index 0 budget, 1 object limit), always ready;
//           write only while no request is in flight.
// Sequence: one request at a time. The key scan walks the key memory one
//   entry per cycle and ends at the first hit or after the last entry. A get
//   hit then updates the recency ranks and reads the value; a get miss goes
//   straight to the result. A put removes an old copy of the key, evicts the
//   oldest entry while over budget or full, then inserts. A too-large put
//   skips the scan.
// A new request is taken once the last result is in the output register.
// The output register holds a finished result while the next request is
//   taken; a stalled output only holds up the following completion.
// Reset: all entries invalid, zero bytes held, budget 1048576, limit 4096.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bblru_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bblru_pkg::rsp_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);
  import bblru_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  // sequencer
  bblru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  bblru_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### design/bblru_datapath.sv
// ----------------------------------------------------------------------------
// bblru_datapath
// Entry stores, recency ranks, byte accounting, key scan and result registers.
// ----------------------------------------------------------------------------
module bblru_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bblru_pkg::req_t    in_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  bblru_pkg::ctl_cmd_t cmd,
  output bblru_pkg::dp_sts_t sts,
  input  logic               out_stall,
  output logic               out_valid,
  output bblru_pkg::rsp_t    out_data
);
  import bblru_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // entry memories
  logic [31:0] key_mem   [ENTRIES];
  logic [31:0] size_mem  [ENTRIES];
  logic [31:0] value_mem [ENTRIES];
  logic [31:0] key_q, size_q, value_q;

  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [31:0]        bytes_r;
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        budget_r, limit_r;
  req_t               item_r;

  logic [IDX_W-1:0] scan_addr_r, cmp_addr_r, hit_slot_r, victim_r;
  logic             cmp_vld_r;
  logic [1:0]       pend_status_r;
  logic [31:0]      pend_data_r;
  logic             out_valid_r;
  rsp_t             out_data_r;

  logic [IDX_W-1:0] victim_c, free_c, size_addr, op_slot, op_rank;
  logic [CNT_W-1:0] cnt_m1;
  logic             hit_now;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= 32'd1048576;
      limit_r  <= 32'd4096;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUDGET) budget_r <= cfg_data;
      else                         limit_r  <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  // oldest entry and lowest free slot
  assign cnt_m1 = count_r - CNT_W'(1);
  always_comb begin
    victim_c = '0;
    free_c   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && rank_r[i] == cnt_m1[IDX_W-1:0]) victim_c = IDX_W'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_c = IDX_W'(i);
    end
  end

  // memory ports
  assign size_addr = cmd.size_rd_victim ? victim_c : hit_slot_r;
  always_ff @(posedge clk) begin
    key_q   <= key_mem[scan_addr_r];
    size_q  <= size_mem[size_addr];
    value_q <= value_mem[hit_slot_r];
    if (cmd.insert) begin
      key_mem[free_c]   <= item_r.key;
      size_mem[free_c]  <= item_r.object_size;
      value_mem[free_c] <= item_r.value_word;
    end
  end

  // key scan, one entry per cycle
  assign hit_now = cmp_vld_r && valid_r[cmp_addr_r] && (key_q == item_r.key);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      cmp_vld_r   <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_addr_r <= '0;
      cmp_vld_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
      cmp_vld_r   <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.scan_step) cmp_addr_r <= scan_addr_r;
    if (cmd.scan_step && hit_now) hit_slot_r <= cmp_addr_r;
    if (cmd.size_rd_victim) victim_r <= victim_c;
  end

  // rank and occupancy updates
  assign op_slot = cmd.remove_victim ? victim_r : hit_slot_r;
  assign op_rank = rank_r[op_slot];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bytes_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (cmd.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] < op_rank) rank_r[i] <= rank_r[i] + IDX_W'(1);
      end
      rank_r[op_slot] <= '0;
    end else if (cmd.remove_hit || cmd.remove_victim) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] > op_rank) rank_r[i] <= rank_r[i] - IDX_W'(1);
      end
      rank_r[op_slot]  <= '0;
      valid_r[op_slot] <= 1'b0;
      bytes_r          <= bytes_r - size_q;
      count_r          <= count_r - CNT_W'(1);
    end else if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i]) rank_r[i] <= rank_r[i] + IDX_W'(1);
      end
      rank_r[free_c]  <= '0;
      valid_r[free_c] <= 1'b1;
      bytes_r         <= bytes_r + item_r.object_size;
      count_r         <= count_r + CNT_W'(1);
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_status_r <= cmd.pend_status;
      pend_data_r   <= cmd.pend_use_value ? value_q : 32'd0;
    end
    if (cmd.out_load) begin
      out_data_r.status   <= pend_status_r;
      out_data_r.data_out <= pend_data_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  assign sts.is_get     = (item_r.kind == KIND_GET);
  assign sts.too_big    = (item_r.object_size > limit_r);
  assign sts.scan_done  = hit_now || (cmp_vld_r && cmp_addr_r == LAST_IDX);
  assign sts.hit_now    = hit_now;
  assign sts.need_evict = (count_r != '0) &&
                          (({1'b0, bytes_r} + {1'b0, item_r.object_size}) > {1'b0, budget_r});
  assign sts.full       = (count_r == CNT_W'(ENTRIES));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

### design/bblru_ctrl.sv
// ----------------------------------------------------------------------------
// bblru_ctrl
// Sequencer for lookup, removal, eviction, insertion and result hand-off.
// ----------------------------------------------------------------------------
module bblru_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bblru_pkg::dp_sts_t   sts,
  output bblru_pkg::ctl_cmd_t  cmd
);
  import bblru_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_RD_OLD = 4'd3;
  localparam logic [3:0] S_REM    = 4'd4;
  localparam logic [3:0] S_EVQ    = 4'd5;
  localparam logic [3:0] S_EVA    = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_RD_VAL = 4'd8;
  localparam logic [3:0] S_GET    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_get && sts.too_big) begin
          cmd.pend_load   = 1'b1;
          cmd.pend_status = ST_TOO_BIG;
          state_nxt       = S_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          if (sts.is_get) begin
            if (sts.hit_now) begin
              state_nxt = S_RD_VAL;
            end else begin
              cmd.pend_load   = 1'b1;
              cmd.pend_status = ST_MISS;
              state_nxt       = S_FIN;
            end
          end else begin
            state_nxt = sts.hit_now ? S_RD_OLD : S_EVQ;
          end
        end
      end
      S_RD_OLD: state_nxt = S_REM;
      S_REM: begin
        cmd.remove_hit = 1'b1;
        state_nxt      = S_EVQ;
      end
      S_EVQ: begin
        if (sts.need_evict || sts.full) begin
          cmd.size_rd_victim = 1'b1;
          state_nxt          = S_EVA;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_EVA: begin
        cmd.remove_victim = 1'b1;
        state_nxt         = S_EVQ;
      end
      S_INS: begin
        cmd.insert      = 1'b1;
        cmd.pend_load   = 1'b1;
        cmd.pend_status = ST_OK;
        state_nxt       = S_FIN;
      end
      S_RD_VAL: begin
        cmd.touch = 1'b1;
        state_nxt = S_GET;
      end
      S_GET: begin
        cmd.pend_load      = 1'b1;
        cmd.pend_status    = ST_OK;
        cmd.pend_use_value = 1'b1;
        state_nxt          = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### design/bblru_checker.sv
// ----------------------------------------------------------------------------
// bblru_checker
// Port-level checks of the cache core, bound to the top level.
// ----------------------------------------------------------------------------
module bblru_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input bblru_pkg::rsp_t out_data
);
  import bblru_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // status stays within its codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_TOO_BIG ||
                   out_data.status == ST_MISS))
    else $error("bad status code");

  // data is zero unless success
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.data_out == 32'd0)
    else $error("nonzero data on miss or reject");

  // a transfer in is never followed by a transfer in next cycle
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind byte_budget_lru_cache_core bblru_checker u_bblru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/byte_budget_lru_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_checker
// Watches the request, result and register channels of the cache core, keeps
// its own copy of the cache contents and recency order, and compares every
// result transfer with the expected status and data in order.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_checker
  import bblru_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rsp_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  logic [31:0] budget, obj_limit;
  logic [31:0] keys [ENTRIES];
  logic [31:0] sizes [ENTRIES];
  logic [31:0] words [ENTRIES];
  logic        live [ENTRIES];
  int          rank [ENTRIES];
  logic [31:0] held_bytes;
  int          live_n;
  rsp_t        expected_rsp [$];

  assign pending_count = expected_rsp.size();

  function automatic int lookup(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && keys[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int s);
    int r;
    r = rank[s];
    live[s] = 1'b0;
    held_bytes -= sizes[s];
    live_n--;
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && rank[i] > r) rank[i]--;
    rank[s] = 0;
  endfunction

  function automatic void drop_oldest();
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && rank[i] == live_n - 1) begin
        drop_entry(i);
        return;
      end
  endfunction

  // compute the result of one request and update the cache copy
  function automatic rsp_t cache_access(req_t q);
    rsp_t r;
    int s, r0;
    r = '0;
    if (q.kind == KIND_GET) begin
      s = lookup(q.key);
      if (s < 0) begin
        r.status = ST_MISS;
      end else begin
        r0 = rank[s];
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && rank[i] < r0) rank[i]++;
        rank[s] = 0;
        r.data_out = words[s];
      end
      return r;
    end
    if (q.object_size > obj_limit) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    s = lookup(q.key);
    if (s >= 0) drop_entry(s);
    while (live_n > 0 && ({32'd0, held_bytes} + {32'd0, q.object_size}) > {32'd0, budget})
      drop_oldest();
    if (live_n >= ENTRIES) drop_oldest();
    s = 0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!live[i]) s = i;
    for (int i = 0; i < ENTRIES; i++)
      if (live[i]) rank[i]++;
    live[s] = 1'b1;
    rank[s] = 0;
    keys[s] = q.key;
    sizes[s] = q.object_size;
    words[s] = q.value_word;
    held_bytes += q.object_size;
    live_n++;
    return r;
  endfunction

  // track transfers on all three channels
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      budget = 32'd1048576;
      obj_limit = 32'd4096;
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      held_bytes = '0;
      live_n = 0;
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUDGET) budget = cfg_data;
        else obj_limit = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time,
                   out_data.status, out_data.data_out);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (want.status !== out_data.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            fail_count++;
          end
          if (want.data_out !== out_data.data_out) begin
            $display("%0t: data_out expected %h actual %h", $time,
                     want.data_out, out_data.data_out);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_rsp.push_back(cache_access(in_data));
    end
  end

endmodule

### dv/byte_budget_lru_cache_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_core_test
// Drives directed and random put/get traffic over several budget and limit
// settings with random idling on both sides, and reports the verdict.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_core_test;
  import bblru_pkg::*;

  localparam int MAX_CYCLES = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_BUDGET;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending_count;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  logic [31:0] key_pool [16];

  byte_budget_lru_cache_core dut (.*);

  byte_budget_lru_cache_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // the core stalls right after a transfer, so the low cycle costs nothing
  task automatic send_req(logic kind, logic [31:0] k, logic [31:0] sz, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{kind: kind, key: k, object_size: sz, value_word: val};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly reused keys and small sizes so hits and evictions happen often
  task automatic random_traffic(int n, logic [31:0] size_max);
    logic [31:0] k, sz;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
      case ($urandom_range(9))
        0: sz = $urandom;
        1: sz = '0;
        default: sz = $urandom_range(size_max);
      endcase
      send_req($urandom_range(1) ? KIND_GET : KIND_PUT, k, sz, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, misses, too big, overwrite, zero size, huge object
    send_req(KIND_GET, 32'h0, 32'h0, 32'h0);
    send_req(KIND_PUT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_req(KIND_GET, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_req(KIND_PUT, 32'hFFFF_FFFF, 32'd4096, 32'h1234_5678);
    send_req(KIND_PUT, 32'h5555_5555, 32'd4097, 32'h1);
    send_req(KIND_PUT, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h2);
    send_req(KIND_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_req(KIND_PUT, 32'hFFFF_FFFF, 32'd100, 32'hAAAA_5555);
    send_req(KIND_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_req(KIND_GET, 32'h5555_5555, 32'h0, 32'h0);
    // fill past 64 entries to force table-full eviction
    for (int i = 0; i < 66; i++) send_req(KIND_PUT, 32'h100 + i, 32'd1, i);
    send_req(KIND_GET, 32'h100, 32'h0, 32'h0);
    send_req(KIND_GET, 32'h141, 32'h0, 32'h0);
    drain();

    // tiny budget, huge limit: objects above the budget
    write_reg(CFG_BUDGET, 32'd50);
    write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
    send_req(KIND_PUT, 32'h7, 32'hFFFF_FFFF, 32'h77);
    send_req(KIND_GET, 32'h7, 32'h0, 32'h0);
    send_idle_pct = 24; recv_idle_pct = 57;
    random_traffic(200, 40);
    drain();

    // budget and limit at zero, then lowered budget under held bytes
    write_reg(CFG_BUDGET, 32'd0);
    write_reg(CFG_LIMIT, 32'd0);
    random_traffic(80, 2);
    drain();
    write_reg(CFG_BUDGET, 32'hFFFF_FFFF);
    write_reg(CFG_LIMIT, 32'd1000);
    send_idle_pct = 57; recv_idle_pct = 24;
    random_traffic(250, 1000);
    drain();
    write_reg(CFG_BUDGET, 32'd3000);

    // long receiver hold-off while requests keep coming
    hold_cycles = 400;
    send_idle_pct = 0; recv_idle_pct = 0;
    random_traffic(30, 1000);
    drain();

    // back to reset values, no idling
    write_reg(CFG_BUDGET, 32'd1048576);
    write_reg(CFG_LIMIT, 32'd4096);
    random_traffic(300, 8192);
    drain();
    write_reg(CFG_BUDGET, 32'd20000);
    random_traffic(100, 4096);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### byte_budget_lru_cache_core.f
design/bblru_pkg.sv
design/bblru_datapath.sv
design/bblru_ctrl.sv
design/byte_budget_lru_cache_core.sv
design/bblru_checker.sv
dv/byte_budget_lru_cache_checker.sv
dv/byte_budget_lru_cache_core_test.sv
